// File: src/pfi_pkg.sv
// ----------------------------------------------------------------------------
// Palette fade interpolator package
// Widths, command and register codes, sequencer states and the request
// structure for the shared channel unit.
// ----------------------------------------------------------------------------
package pfi_pkg;

  localparam int PALETTE_ENTRIES_DEF = 16;

  localparam int COLOR_W = 12;
  localparam int CHAN_W  = 3;
  localparam int STEP_W  = 12;
  localparam int DELAY_W = 15;
  localparam int SEL_W   = 2;
  localparam int ENTRY_W = 4;
  localparam int CMD_W   = 2;
  localparam int NUM_W   = 15;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [COLOR_W-1:0] CH_HI_MASK  = 12'he00;
  localparam logic [COLOR_W-1:0] CH_MID_MASK = 12'h0e0;
  localparam logic [COLOR_W-1:0] CH_LO_MASK  = 12'h00e;
  localparam logic [COLOR_W-1:0] COLOR_MASK  = CH_HI_MASK | CH_MID_MASK | CH_LO_MASK;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] REG_TOTAL  = 2'd0;
  localparam logic [1:0] REG_DELAY  = 2'd1;
  localparam logic [1:0] REG_SELECT = 2'd2;

  localparam logic [1:0] CH_HI  = 2'd0;
  localparam logic [1:0] CH_MID = 2'd1;
  localparam logic [1:0] CH_LO  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START_OUT,
    ST_MUL,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic              load;
    logic [CHAN_W-1:0] start_ch;
    logic [CHAN_W-1:0] end_ch;
  } mix_req_t;

endpackage

// File: src/pfi_mix_unit.sv
// ----------------------------------------------------------------------------
// Palette fade channel unit
// Forms start*left + end*done for one 3-bit channel into a register, then
// divides it by total_steps with a three-step restoring divider.
// ----------------------------------------------------------------------------
module pfi_mix_unit (
  input  logic                       clk,
  input  pfi_pkg::mix_req_t          req,
  input  logic [pfi_pkg::STEP_W-1:0] left,
  input  logic [pfi_pkg::STEP_W-1:0] done,
  input  logic [pfi_pkg::STEP_W-1:0] total,
  output logic [pfi_pkg::CHAN_W-1:0] quotient
);
  import pfi_pkg::*;

  logic [NUM_W-1:0] prod_s;
  logic [NUM_W-1:0] prod_e;
  logic [NUM_W-1:0] num;
  logic [NUM_W-1:0] div4;
  logic [NUM_W-1:0] div2;
  logic [NUM_W-1:0] div1;
  logic [NUM_W-1:0] rem1;
  logic [NUM_W-1:0] rem2;
  logic             q2;
  logic             q1;
  logic             q0;

  assign prod_s = NUM_W'(req.start_ch) * NUM_W'(left);
  assign prod_e = NUM_W'(req.end_ch) * NUM_W'(done);

  // The sum never exceeds 7 * 4095, so it fits without wrapping.
  always_ff @(posedge clk) begin
    if (req.load) begin
      num <= prod_s + prod_e;
    end
  end

  // The quotient is at most 7 because left + done equals total.
  assign div4 = {1'b0, total, 2'b00};
  assign div2 = {2'b00, total, 1'b0};
  assign div1 = {3'b000, total};

  assign q2   = (num >= div4);
  assign rem1 = q2 ? (num - div4) : num;
  assign q1   = (rem1 >= div2);
  assign rem2 = q1 ? (rem1 - div2) : rem1;
  assign q0   = (rem2 >= div1);

  assign quotient = {q2, q1, q0};

endmodule

// File: src/palette_fade_interpolator.sv
// ----------------------------------------------------------------------------
// Palette fade interpolator
// Holds start and end colors for each palette entry and emits either the
// start palette or one interpolated step of the fade, one entry per result.
// ----------------------------------------------------------------------------
// Channel   Ports                                        Transfer
// command   start, busy, command, entry_index,          start high, busy low
//           start_color, end_color
// result    strobe, palette_number, entry_number,       strobe high, one cycle
//           color, delay_add, last
// config    psel, penable, pwrite, paddr, pwdata,        APB access phase
//           prdata, pready
//
// A load or an ignored command leaves the sequencer idle. A start fade visits
// a memory read state and then an output state for each entry. A step visits
// a read state for each entry, then a multiply state and a divide state
// on the shared channel unit for each of the three channels.
// Reset clears the sequencer, step count, config registers and strobe; the
// palette memories are undefined until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module palette_fade_interpolator #(
  parameter int PALETTE_ENTRIES = pfi_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pfi_pkg::CMD_W-1:0]   command,
  input  logic [pfi_pkg::ENTRY_W-1:0] entry_index,
  input  logic [pfi_pkg::COLOR_W-1:0] start_color,
  input  logic [pfi_pkg::COLOR_W-1:0] end_color,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pfi_pkg::ADDR_W-1:0]  paddr,
  input  logic [pfi_pkg::DATA_W-1:0]  pwdata,
  output logic [pfi_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic                        strobe,
  output logic [pfi_pkg::SEL_W-1:0]   palette_number,
  output logic [pfi_pkg::ENTRY_W-1:0] entry_number,
  output logic [pfi_pkg::COLOR_W-1:0] color,
  output logic [pfi_pkg::DELAY_W-1:0] delay_add,
  output logic                        last
);
  import pfi_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_ENT = AW'(PALETTE_ENTRIES - 1);

  logic [STEP_W-1:0]  total_steps;
  logic [DELAY_W-1:0] step_delay;
  logic [SEL_W-1:0]   palette_select;

  logic [COLOR_W-1:0] start_mem [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] end_mem   [PALETTE_ENTRIES];
  logic [COLOR_W-1:0] start_rd;
  logic [COLOR_W-1:0] end_rd;

  state_t             state;
  state_t             state_next;
  logic [AW-1:0]      ent;
  logic [AW-1:0]      ent_next;
  logic [1:0]         ch;
  logic [1:0]         ch_next;
  logic               step_mode;
  logic               step_mode_next;
  logic [STEP_W-1:0]  steps_done;
  logic [STEP_W-1:0]  steps_done_next;
  logic [CHAN_W-1:0]  q_hi;
  logic [CHAN_W-1:0]  q_mid;
  logic [CHAN_W-1:0]  quot;
  logic [STEP_W-1:0]  left;
  mix_req_t           req;

  logic               accept;
  logic               cfg_write;
  logic               load_write;
  logic               out_load;
  logic [COLOR_W-1:0] out_color;

  assign accept     = start && !busy;
  assign busy       = (state != ST_IDLE);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign load_write = accept && (command == CMD_LOAD) &&
                      (32'(entry_index) < 32'(PALETTE_ENTRIES));
  assign pready     = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps    <= '0;
      step_delay     <= '0;
      palette_select <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_TOTAL:  total_steps    <= pwdata[STEP_W-1:0];
        REG_DELAY:  step_delay     <= pwdata[DELAY_W-1:0];
        REG_SELECT: palette_select <= pwdata[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TOTAL:  prdata = DATA_W'(total_steps);
      REG_DELAY:  prdata = DATA_W'(step_delay);
      REG_SELECT: prdata = DATA_W'(palette_select);
      default:    prdata = '0;
    endcase
  end

  // Palette memories with registered read at the current entry.
  always_ff @(posedge clk) begin
    if (load_write) begin
      start_mem[AW'(entry_index)] <= start_color;
      end_mem[AW'(entry_index)]   <= end_color;
    end
    if (state == ST_READ) begin
      start_rd <= start_mem[ent];
      end_rd   <= end_mem[ent];
    end
  end

  assign left = total_steps - steps_done;

  always_comb begin
    req.load = (state == ST_MUL);
    unique case (ch)
      CH_HI: begin
        req.start_ch = start_rd[11:9];
        req.end_ch   = end_rd[11:9];
      end
      CH_MID: begin
        req.start_ch = start_rd[7:5];
        req.end_ch   = end_rd[7:5];
      end
      CH_LO: begin
        req.start_ch = start_rd[3:1];
        req.end_ch   = end_rd[3:1];
      end
      default: begin
        req.start_ch = '0;
        req.end_ch   = '0;
      end
    endcase
  end

  pfi_mix_unit u_mix (
    .clk      (clk),
    .req      (req),
    .left     (left),
    .done     (steps_done),
    .total    (total_steps),
    .quotient (quot)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ent        <= '0;
      ch         <= CH_HI;
      step_mode  <= 1'b0;
      steps_done <= '0;
    end else begin
      state      <= state_next;
      ent        <= ent_next;
      ch         <= ch_next;
      step_mode  <= step_mode_next;
      steps_done <= steps_done_next;
    end
  end

  always_comb begin
    state_next      = state;
    ent_next        = ent;
    ch_next         = ch;
    step_mode_next  = step_mode;
    steps_done_next = steps_done;
    out_load        = 1'b0;
    out_color       = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_START: begin
              steps_done_next = '0;
              step_mode_next  = 1'b0;
              ent_next        = '0;
              state_next      = ST_READ;
            end
            CMD_STEP: begin
              if ((total_steps != '0) && (steps_done < total_steps)) begin
                steps_done_next = steps_done + STEP_W'(1);
                step_mode_next  = 1'b1;
                ent_next        = '0;
                state_next      = ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        ch_next    = CH_HI;
        state_next = step_mode ? ST_MUL : ST_START_OUT;
      end
      ST_START_OUT: begin
        out_load  = 1'b1;
        out_color = start_rd & COLOR_MASK;
        if (ent == LAST_ENT) begin
          state_next = ST_IDLE;
        end else begin
          ent_next   = ent + AW'(1);
          state_next = ST_READ;
        end
      end
      ST_MUL: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (ch == CH_LO) begin
          out_load  = 1'b1;
          out_color = {q_hi, 1'b0, q_mid, 1'b0, quot, 1'b0};
          if (ent == LAST_ENT) begin
            state_next = ST_IDLE;
          end else begin
            ent_next   = ent + AW'(1);
            state_next = ST_READ;
          end
        end else begin
          ch_next    = ch + 2'd1;
          state_next = ST_MUL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      if (ch == CH_HI) begin
        q_hi <= quot;
      end
      if (ch == CH_MID) begin
        q_mid <= quot;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      palette_number <= palette_select;
      entry_number   <= ENTRY_W'(ent);
      color          <= out_color;
      delay_add      <= step_mode ? step_delay : '0;
      last           <= (ent == LAST_ENT);
    end
  end

`ifndef SYNTHESIS
  a_strobe_from_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result transfer without a running command");

  a_strobe_spaced: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("results on consecutive cycles");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("sequencer still running after the final entry");

  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (accept && (command == CMD_STEP) && (steps_done >= total_steps)) |=> !busy)
    else $error("finished fade started a step run");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (busy && step_mode) |-> ((steps_done <= total_steps) && (steps_done != '0)))
    else $error("step count out of range during a step run");
`endif

endmodule
